/* rtl/bpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    // Widths and defaults
    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_W           = 16;
    localparam int CNT_W           = 4;
    localparam int IDX_W           = 3;
    localparam int BOUND_W         = CFG_W + 1;
    localparam int NUM_BEACONS     = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CFG_W-1:0] TOL_RESET = 16'd50;
    localparam logic [CNT_W-1:0] REQ_RESET = 4'd3;
    localparam logic [CNT_W-1:0] CNT_MAX   = 4'd15;
    localparam logic [CNT_W-1:0] CNT_ONE   = 4'd1;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_PERIOD_G       = 3'd0,
        REG_PERIOD_B       = 3'd1,
        REG_PERIOD_R       = 3'd2,
        REG_PERIOD_L       = 3'd3,
        REG_TOLERANCE      = 3'd4,
        REG_REQUIRED_COUNT = 3'd5
    } cfg_reg_t;

    // Beacon identities, also the match priority order
    typedef enum logic [1:0] {
        BCN_G = 2'd0,
        BCN_B = 2'd1,
        BCN_R = 2'd2,
        BCN_L = 2'd3
    } beacon_t;

    // Window settings seen by the classifier
    typedef struct packed {
        logic [NUM_BEACONS-1:0][CFG_W-1:0] period;
        logic [CFG_W-1:0]                  tolerance;
    } window_cfg_t;

    // One classified beat passed from front to back
    typedef struct packed {
        logic    look;
        logic    hit;
        beacon_t id;
    } class_beat_t;

endpackage

`default_nettype wire

/* rtl/bpc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpc_front
    import bpc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_cmd,
    input  wire logic [TIMER_WIDTH-1:0] s_stamp,
    input  wire window_cfg_t            win_cfg,
    output logic                        out_valid,
    output class_beat_t                 out_beat,
    input  wire logic                   out_ready
);

    localparam int CMP_W = (TIMER_WIDTH > BOUND_W) ? TIMER_WIDTH : BOUND_W;

    logic                   stage_valid_reg;
    logic                   stage_look_reg;
    logic [TIMER_WIDTH-1:0] period_reg;
    logic [TIMER_WIDTH-1:0] last_stamp_reg;
    logic [NUM_BEACONS-1:0] in_win;
    logic                   take;

    assign s_ready = !stage_valid_reg || out_ready;
    assign take    = s_valid && s_ready;

    // Stage control and previous stamp
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            last_stamp_reg  <= '0;
        end else begin
            if (s_ready) begin
                stage_valid_reg <= s_valid;
            end
            if (take && !s_cmd) begin
                last_stamp_reg <= s_stamp;
            end
        end
    end

    // Period: modular difference, wraps with the timer
    always_ff @(posedge aclk) begin
        if (take) begin
            stage_look_reg <= s_cmd;
            period_reg     <= s_stamp - last_stamp_reg;
        end
    end

    // Window test per beacon; lower bound clamps at zero, upper does not wrap
    always_comb begin
        logic [CFG_W-1:0]   lo;
        logic [BOUND_W-1:0] hi;
        logic [CMP_W-1:0]   per;
        per = CMP_W'(period_reg);
        for (int b = 0; b < NUM_BEACONS; b++) begin
            lo = (win_cfg.period[b] > win_cfg.tolerance) ?
                 (win_cfg.period[b] - win_cfg.tolerance) : '0;
            hi = {1'b0, win_cfg.period[b]} + {1'b0, win_cfg.tolerance};
            in_win[b] = (per >= CMP_W'(lo)) && (per <= CMP_W'(hi));
        end
    end

    // First hit in G, B, R, L order wins
    always_comb begin
        out_beat.look = stage_look_reg;
        out_beat.hit  = 1'b0;
        out_beat.id   = BCN_G;
        for (int b = NUM_BEACONS - 1; b >= 0; b--) begin
            if (in_win[b]) begin
                out_beat.hit = 1'b1;
                out_beat.id  = beacon_t'(2'(b));
            end
        end
    end

    assign out_valid = stage_valid_reg;

endmodule

`default_nettype wire

/* rtl/bpc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpc_queue
    import bpc_pkg::*;
#(
    parameter int WIDTH = $bits(class_beat_t),
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;
    logic             push;
    logic             pop;

    assign push_ready = (level_reg != LVL_W'(DEPTH));
    assign pop_valid  = (level_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/bpc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpc_back
    import bpc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire class_beat_t      in_beat,
    input  wire logic [CNT_W-1:0] required_count,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [1:0]            m_beacon,
    output logic                  m_side_report
);

    logic             run_valid_reg;
    beacon_t          run_id_reg;
    logic [CNT_W-1:0] run_count_reg;
    logic             looking_reg;
    logic             m_valid_reg;
    beacon_t          beacon_reg;
    logic             side_reg;

    logic             take;
    logic             same;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] need;
    logic             fire;

    assign in_ready = !m_valid_reg || m_ready;
    assign take     = in_valid && in_ready;

    // Run bookkeeping for the incoming beat
    always_comb begin
        need       = (required_count == '0) ? CNT_ONE : required_count;
        same       = run_valid_reg && (run_id_reg == in_beat.id);
        count_next = !same ? CNT_ONE :
                     (run_count_reg == CNT_MAX) ? run_count_reg : run_count_reg + 1'b1;
        fire       = !in_beat.look && in_beat.hit && (count_next == need);
    end

    // Run, looking flag and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_valid_reg <= 1'b0;
            run_id_reg    <= BCN_G;
            run_count_reg <= '0;
            looking_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (take) begin
                priority if (in_beat.look) begin
                    looking_reg <= 1'b1;
                end else if (!in_beat.hit) begin
                    run_valid_reg <= 1'b0;
                    run_count_reg <= '0;
                end else if (fire) begin
                    run_valid_reg <= 1'b0;
                    run_count_reg <= '0;
                    looking_reg   <= 1'b0;
                    m_valid_reg   <= 1'b1;
                end else begin
                    run_valid_reg <= 1'b1;
                    run_id_reg    <= in_beat.id;
                    run_count_reg <= count_next;
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (take && fire) begin
            beacon_reg <= in_beat.id;
            side_reg   <= looking_reg &&
                          ((in_beat.id == BCN_R) || (in_beat.id == BCN_L));
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_beacon      = beacon_reg;
    assign m_side_report = side_reg;

endmodule

`default_nettype wire

/* rtl/beacon_period_classifier.sv */
`timescale 1ns / 1ps
`default_nettype none

// Beacon period classifier. Each input beat is either a capture stamp from a
// free-running TIMER_WIDTH-bit timer (s_cmd = 0) or a request to start looking
// (s_cmd = 1). The period since the previous stamp (modulo the timer range) is
// matched against the G, B, R and L windows, nominal +/- tolerance, first match
// wins; a run of required_count equal matches gives one result beat naming the
// beacon, with m_side_report set for R or L while looking. One beat is taken
// every cycle while s_ready is high; the beat completing the run passes
// through the period/classify stage register and the two-entry queue, after
// which its result lands in the output register. Write configuration only
// while no beats are in flight.
module beacon_period_classifier
    import bpc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_cmd,
    input  wire logic [TIMER_WIDTH-1:0] s_stamp,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_beacon,
    output logic                        m_side_report,
    input  wire logic                   cfg_we,
    input  wire logic [IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata
);

    logic [NUM_BEACONS-1:0][CFG_W-1:0] period_reg;
    logic [CFG_W-1:0]                  tolerance_reg;
    logic [CNT_W-1:0]                  required_count_reg;
    window_cfg_t                       win_cfg;

    logic                              fr_valid;
    logic                              fr_ready;
    class_beat_t                       fr_beat;
    logic                              q_valid;
    logic                              q_ready;
    class_beat_t                       q_beat;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg         <= '0;
            tolerance_reg      <= TOL_RESET;
            required_count_reg <= REQ_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PERIOD_G:       period_reg[BCN_G]  <= cfg_wdata;
                REG_PERIOD_B:       period_reg[BCN_B]  <= cfg_wdata;
                REG_PERIOD_R:       period_reg[BCN_R]  <= cfg_wdata;
                REG_PERIOD_L:       period_reg[BCN_L]  <= cfg_wdata;
                REG_TOLERANCE:      tolerance_reg      <= cfg_wdata;
                REG_REQUIRED_COUNT: required_count_reg <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign win_cfg.period    = period_reg;
    assign win_cfg.tolerance = tolerance_reg;

    // Front: period and window classification
    bpc_front #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_stamp   (s_stamp),
        .win_cfg   (win_cfg),
        .out_valid (fr_valid),
        .out_beat  (fr_beat),
        .out_ready (fr_ready)
    );

    // Decoupling queue
    bpc_queue #(
        .WIDTH ($bits(class_beat_t)),
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_beat),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_beat)
    );

    // Back: run counting, looking flag, result register
    bpc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (q_valid),
        .in_ready       (q_ready),
        .in_beat        (q_beat),
        .required_count (required_count_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_beacon       (m_beacon),
        .m_side_report  (m_side_report)
    );

    // Side report only ever flags R or L
    a_side_is_rl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_side_report) |-> ((m_beacon == BCN_R) || (m_beacon == BCN_L)))
        else $error("side report on a beacon other than R or L");

    // A classified beat held by a full queue is kept intact
    a_front_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (fr_valid && !fr_ready) |=> (fr_valid && $stable(fr_beat)))
        else $error("front stage dropped or changed a stalled beat");

    // Queue head stays put while the back end is stalled
    a_queue_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !q_ready) |=> (q_valid && $stable(q_beat)))
        else $error("queue head changed while back end stalled");

endmodule

`default_nettype wire

/* bench/beacon_period_classifier_tb.sv */
`timescale 1ns / 1ps

module beacon_period_classifier_tb;
    import bpc_pkg::*;

    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 90;
    localparam int PRESSURE_BEATS = 30;

    localparam logic [2:0] STREAK_NONE = 3'd4;

    // Indexes past the register list; writes there must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum logic { CMD_CAPTURE = 1'b0, CMD_LOOK = 1'b1 } beat_cmd_t;
    typedef enum logic { ROW_BEAT, ROW_WRITE } row_kind_t;

    typedef struct packed {
        beacon_t beacon;
        logic    side;
    } beacon_report_t;

    typedef struct packed {
        row_kind_t        kind;
        beat_cmd_t        cmd;
        logic [IDX_W-1:0] index;
        logic [15:0]      value;
        logic             pinned;
        logic             p_hit;
        beacon_t          p_beacon;
        logic             p_side;
    } script_row_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_cmd;
    logic [15:0]      s_stamp;
    logic             m_valid;
    logic             m_ready;
    logic [1:0]       m_beacon;
    logic             m_side_report;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    // Directed rows may carry a hand-written expectation alongside the beat
    logic           pin_active;
    logic           pin_hit;
    beacon_report_t pin_report;

    int unsigned    hold_asks;
    int             mismatches = 0;
    logic           tx_burst = 1'b0;

    // Predictor state and its copy of the registers
    logic [15:0] prev_stamp;
    logic [2:0]  streak_id;
    logic [3:0]  streak_len;
    logic        look_armed;
    logic [15:0] win_nominal [NUM_BEACONS];
    logic [15:0] win_tol;
    logic [3:0]  confirm_need;

    beacon_report_t expected_beacons [$];
    script_row_t    script [$];

    beacon_period_classifier i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_stamp       (s_stamp),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_beacon      (m_beacon),
        .m_side_report (m_side_report),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Window test: lower edge clamps at zero, upper edge does not wrap
    function automatic logic in_window(input logic [15:0] ticks, input logic [15:0] nominal);
        logic [16:0] lo;
        logic [16:0] hi;
        lo = (nominal > win_tol) ? {1'b0, nominal - win_tol} : 17'd0;
        hi = {1'b0, nominal} + {1'b0, win_tol};
        return ({1'b0, ticks} >= lo) && ({1'b0, ticks} <= hi);
    endfunction

    // Advance the predictor by one beat; returns 1 when a beacon is confirmed
    function automatic logic classify_capture(input beat_cmd_t cmd, input logic [15:0] stamp,
                                              output beacon_report_t rep);
        logic [15:0] ticks;
        logic [2:0]  hit;
        logic [3:0]  need;
        int          k;
        rep = '0;
        if (cmd == CMD_LOOK) begin
            look_armed = 1'b1;
            return 1'b0;
        end
        ticks = stamp - prev_stamp;
        prev_stamp = stamp;
        // walk backwards so the first window in priority order wins
        hit = STREAK_NONE;
        for (k = NUM_BEACONS - 1; k >= 0; k--) begin
            if (in_window(ticks, win_nominal[k])) hit = 3'(k);
        end
        if (hit == STREAK_NONE) begin
            streak_id = STREAK_NONE;
            streak_len = '0;
            return 1'b0;
        end
        if (hit == streak_id) begin
            if (streak_len != CNT_MAX) streak_len = streak_len + CNT_ONE;
        end else begin
            streak_id = hit;
            streak_len = CNT_ONE;
        end
        need = (confirm_need == '0) ? CNT_ONE : confirm_need;
        if (streak_len != need) return 1'b0;
        rep.beacon = beacon_t'(streak_id[1:0]);
        rep.side = look_armed && (rep.beacon == BCN_R || rep.beacon == BCN_L);
        look_armed = 1'b0;
        streak_len = '0;
        streak_id = STREAK_NONE;
        return 1'b1;
    endfunction

    // Scoreboard: tracks writes and accepted beats, checks result beats
    always @(posedge aclk) begin : scoreboard
        beacon_report_t want;
        beacon_report_t predicted;
        logic           made;
        if (aresetn !== 1'b1) begin
            prev_stamp = '0;
            streak_id = STREAK_NONE;
            streak_len = '0;
            look_armed = 1'b0;
            win_nominal = '{default: '0};
            win_tol = TOL_RESET;
            confirm_need = REQ_RESET;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_PERIOD_G:       win_nominal[BCN_G] = cfg_wdata;
                    REG_PERIOD_B:       win_nominal[BCN_B] = cfg_wdata;
                    REG_PERIOD_R:       win_nominal[BCN_R] = cfg_wdata;
                    REG_PERIOD_L:       win_nominal[BCN_L] = cfg_wdata;
                    REG_TOLERANCE:      win_tol = cfg_wdata;
                    REG_REQUIRED_COUNT: confirm_need = cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_beacons.size() == 0) begin
                    $error("unexpected result beat: m_beacon %0d m_side_report %0d",
                           m_beacon, m_side_report);
                    mismatches++;
                end else begin
                    want = expected_beacons.pop_front();
                    if (m_beacon !== want.beacon) begin
                        $error("m_beacon: expected %0d, got %0d", want.beacon, m_beacon);
                        mismatches++;
                    end
                    if (m_side_report !== want.side) begin
                        $error("m_side_report: expected %0d, got %0d", want.side, m_side_report);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                made = classify_capture(beat_cmd_t'(s_cmd), s_stamp, predicted);
                if (pin_active) begin
                    made = pin_hit;
                    predicted = pin_report;
                end
                if (made) expected_beacons.push_back(predicted);
            end
        end
    end

    // Result side: random stall per beat, long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        int unsigned holds_served;
        logic        rx_burst;
        holds_served = 0;
        rx_burst = 1'b0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (hold_asks != holds_served) begin
                stall = HOLD_CYCLES;
                holds_served++;
            end else if (rx_burst) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 15);
            end
            if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Offer one beat after a random gap and wait for it to be taken
    task automatic offer_beat(input beat_cmd_t cmd, input logic [15:0] stamp, input logic eager,
                              input logic pinned, input logic p_hit, input beacon_report_t p_rep);
        int unsigned gap;
        gap = (eager || tx_burst) ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 23) == 0) tx_burst = !tx_burst;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_stamp <= stamp;
        pin_active <= pinned;
        pin_hit <= p_hit;
        pin_report <= p_rep;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    // Stop sending and wait for every outstanding report, then let the pipe empty
    task automatic settle();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (expected_beacons.size() != 0 && waited < DRAIN_LIMIT);
        if (expected_beacons.size() != 0) begin
            $error("%0d expected reports never arrived", expected_beacons.size());
            mismatches++;
            expected_beacons.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic script_row_t beat_row(input beat_cmd_t cmd, input logic [15:0] stamp,
                                             input logic pinned, input logic p_hit,
                                             input beacon_t b, input logic side);
        script_row_t r;
        r = '{ROW_BEAT, cmd, REG_PERIOD_G, stamp, pinned, p_hit, b, side};
        return r;
    endfunction

    function automatic script_row_t write_row(input logic [IDX_W-1:0] idx,
                                              input logic [15:0] value);
        script_row_t r;
        r = '{ROW_WRITE, CMD_CAPTURE, idx, value, 1'b0, 1'b0, BCN_G, 1'b0};
        return r;
    endfunction

    initial begin : stimulus
        int          phase;
        int          sent;
        int          k;
        int          len;
        int          span;
        int          jitter;
        int          choice;
        int          j;
        int          need_now;
        logic [15:0] stamp_now;
        logic [15:0] tol_v;
        logic [3:0]  req_v;
        logic        prev_was_write;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_cmd <= CMD_CAPTURE;
        s_stamp <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        pin_active <= 1'b0;
        pin_hit <= 1'b0;
        pin_report <= '0;
        hold_asks <= 0;

        // Reset settings: every window is [0, 50], three matches confirm
        // first capture is timed from zero
        script.push_back(beat_row(CMD_CAPTURE, 16'd0, 0, 0, BCN_G, 0));
        script.push_back(beat_row(CMD_CAPTURE, 16'd50, 0, 0, BCN_G, 0));
        script.push_back(beat_row(CMD_CAPTURE, 16'd100, 1, 1, BCN_G, 0));
        // look request, then a second one while already looking
        script.push_back(beat_row(CMD_LOOK, 16'hFFFF, 1, 0, BCN_G, 0));
        script.push_back(beat_row(CMD_LOOK, 16'd0, 1, 0, BCN_G, 0));
        // period 51 just misses every window
        script.push_back(beat_row(CMD_CAPTURE, 16'd151, 1, 0, BCN_G, 0));
        // R at 1000, L at the top of the timer range, narrow windows, single match
        script.push_back(write_row(REG_PERIOD_R, 16'd1000));
        script.push_back(write_row(REG_PERIOD_L, 16'hFFFF));
        script.push_back(write_row(REG_TOLERANCE, 16'd10));
        script.push_back(write_row(REG_REQUIRED_COUNT, 16'd1));
        script.push_back(beat_row(CMD_CAPTURE, 16'd1151, 1, 1, BCN_R, 1));
        script.push_back(beat_row(CMD_CAPTURE, 16'd2151, 1, 1, BCN_R, 0));
        script.push_back(beat_row(CMD_LOOK, 16'h5A5A, 1, 0, BCN_G, 0));
        // backwards stamp wraps to a long period
        script.push_back(beat_row(CMD_CAPTURE, 16'd2141, 1, 1, BCN_L, 1));
        script.push_back(beat_row(CMD_CAPTURE, 16'd2140, 1, 1, BCN_L, 0));
        script.push_back(beat_row(CMD_CAPTURE, 16'd2145, 1, 1, BCN_G, 0));
        // count of zero acts as one; G overlaps L and takes priority
        script.push_back(write_row(REG_REQUIRED_COUNT, 16'd0));
        script.push_back(write_row(REG_PERIOD_B, 16'd500));
        script.push_back(write_row(REG_PERIOD_G, 16'hFFFF));
        script.push_back(beat_row(CMD_LOOK, 16'd0, 1, 0, BCN_G, 0));
        script.push_back(beat_row(CMD_CAPTURE, 16'd2144, 1, 1, BCN_G, 0));
        script.push_back(beat_row(CMD_CAPTURE, 16'd2644, 1, 1, BCN_B, 0));
        script.push_back(beat_row(CMD_CAPTURE, 16'd2644, 1, 0, BCN_G, 0));
        // widest tolerance, then writes past the register list that must be dropped
        script.push_back(write_row(REG_TOLERANCE, 16'hFFFF));
        script.push_back(write_row(REG_REQUIRED_COUNT, 16'd2));
        script.push_back(write_row(REG_SPARE_LO, 16'h0000));
        script.push_back(write_row(REG_SPARE_HI, 16'hFFFF));
        script.push_back(beat_row(CMD_CAPTURE, 16'd0, 0, 0, BCN_G, 0));
        script.push_back(beat_row(CMD_CAPTURE, 16'hFFFF, 1, 1, BCN_G, 0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows
        prev_was_write = 1'b0;
        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                if (!prev_was_write) settle();
                write_reg(script[i].index, script[i].value);
                prev_was_write = 1'b1;
            end else begin
                offer_beat(script[i].cmd, script[i].value, 1'b0, script[i].pinned,
                           script[i].p_hit, '{script[i].p_beacon, script[i].p_side});
                prev_was_write = 1'b0;
            end
        end
        stamp_now = 16'hFFFF;

        // Back-pressure: every capture confirms G while the result side holds off
        settle();
        write_reg(REG_REQUIRED_COUNT, 16'd1);
        hold_asks <= hold_asks + 1;
        for (j = 0; j < PRESSURE_BEATS; j++) begin
            stamp_now = 16'($urandom_range(0, 65535));
            offer_beat(CMD_CAPTURE, stamp_now, 1'b1, 1'b0, 1'b0, '0);
        end

        // Random phases, each with fresh settings
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            tol_v = (phase == 1) ? 16'hFFFF :
                    (phase == 2) ? 16'd0 : 16'($urandom_range(0, 300));
            req_v = (phase == 0) ? 4'd1 :
                    (phase == 3) ? 4'd15 :
                    (phase == 4) ? 4'd0 : 4'($urandom_range(1, 15));
            for (k = 0; k < NUM_BEACONS; k++) begin
                write_reg(REG_PERIOD_G + IDX_W'(k),
                          (phase == 1) ? 16'($urandom_range(0, 65535)) :
                          (phase == 5 && k == 0) ? 16'd0 :
                          (phase == 5 && k == 3) ? 16'hFFFF :
                          16'($urandom_range(16, 4000)));
            end
            write_reg(REG_TOLERANCE, tol_v);
            write_reg(REG_REQUIRED_COUNT, {12'($urandom_range(0, 4095)), req_v});

            need_now = (confirm_need == '0) ? 1 : int'(confirm_need);
            span = (int'(win_tol) < 300) ? int'(win_tol) : 300;
            sent = 0;
            while (sent < PHASE_BEATS) begin
                choice = $urandom_range(0, 99);
                if (choice < 8) begin
                    offer_beat(CMD_LOOK, 16'($urandom_range(0, 65535)), 1'b0, 1'b0, 1'b0, '0);
                    sent++;
                end else if (choice < 18) begin
                    stamp_now = 16'($urandom_range(0, 65535));
                    offer_beat(CMD_CAPTURE, stamp_now, 1'b0, 1'b0, 1'b0, '0);
                    sent++;
                end else begin
                    // pulse train of one beacon with jitter, sometimes just outside
                    k = $urandom_range(0, NUM_BEACONS - 1);
                    len = $urandom_range(1, need_now + 2);
                    for (j = 0; j < len && sent < PHASE_BEATS; j++) begin
                        if ($urandom_range(0, 19) == 0) begin
                            offer_beat(CMD_LOOK, 16'($urandom_range(0, 65535)),
                                       1'b0, 1'b0, 1'b0, '0);
                            sent++;
                        end
                        jitter = int'($urandom_range(0, 2 * span + 2)) - span - 1;
                        stamp_now = 16'(stamp_now + win_nominal[k] + jitter);
                        offer_beat(CMD_CAPTURE, stamp_now, 1'b0, 1'b0, 1'b0, '0);
                        sent++;
                    end
                end
                // now and then the sender waits for everything to come back
                if ($urandom_range(0, 59) == 0) settle();
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
rtl/bpc_pkg.sv
rtl/bpc_front.sv
rtl/bpc_queue.sv
rtl/bpc_back.sv
rtl/beacon_period_classifier.sv
bench/beacon_period_classifier_tb.sv
